// ===== rtl/core/dap_pkg.sv =====
// ---------------------------------------------------------------------------
// Decimal amount parser package
// Shared payload types, parser state, character codes and powers of ten.
// ---------------------------------------------------------------------------
`default_nettype none

package dap_pkg;

	localparam int CNT_W = 5;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// largest value that can still be multiplied by ten without wrapping
	localparam logic [63:0] MAX_DIV10 = 64'd1844674407370955161;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SYNTAX   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_SIGN  = 4'b0010,
		PH_INT   = 4'b0100,
		PH_FRAC  = 4'b1000
	} phase_t;

	localparam logic [63:0] POW10 [0:18] = '{
		64'd1,
		64'd10,
		64'd100,
		64'd1000,
		64'd10000,
		64'd100000,
		64'd1000000,
		64'd10000000,
		64'd100000000,
		64'd1000000000,
		64'd10000000000,
		64'd100000000000,
		64'd1000000000000,
		64'd10000000000000,
		64'd100000000000000,
		64'd1000000000000000,
		64'd10000000000000000,
		64'd100000000000000000,
		64'd1000000000000000000
	};

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] amount;
		logic               noncanonical;
		logic [1:0]         status;
	} out_item_t;

	// value: digits as written; scaled: value already shifted to units of 1e-FRACTION_DIGITS
	typedef struct packed {
		logic [63:0]      value;
		logic [63:0]      scaled;
		logic             scaled_big;
		phase_t           phase;
		logic [CNT_W-1:0] frac_cnt;
		logic             neg;
		logic             noncanon;
		logic             nz_frac;
		logic             first_zero;
		status_t          err;
	} state_t;

	typedef struct packed {
		logic [63:0] scaled;
		logic        scaled_big;
		logic        neg;
		logic        noncanon;
		status_t     err;
	} fin_t;

	localparam state_t STATE_RESET = '{
		value:      64'd0,
		scaled:     64'd0,
		scaled_big: 1'b0,
		phase:      PH_START,
		frac_cnt:   '0,
		neg:        1'b0,
		noncanon:   1'b0,
		nz_frac:    1'b0,
		first_zero: 1'b0,
		err:        ST_OK
	};

endpackage

`default_nettype wire

// ===== rtl/core/dap_stream_if.sv =====
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface dap_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/decimal_amount_parser.sv =====
// A result passes from the parser state to the summary register and then the output register.
// Throughput: one byte per cycle; input register, parser state, summary register
// and output register each hand over to the next when it is free or draining.
// Reset clears all stage valid flags and returns the parser to the start of a string.
// ---------------------------------------------------------------------------
// Decimal amount parser
// Streams an ASCII decimal amount and emits a signed fixed-point result.
// ---------------------------------------------------------------------------
`default_nettype none

module decimal_amount_parser #(
	parameter int FRACTION_DIGITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	dap_stream_if.sink   chars,
	dap_stream_if.source results
);

	logic               vld_s1;
	logic [7:0]         char_s1;
	logic               last_s1;
	dap_pkg::state_t    state_q;
	dap_pkg::state_t    state_nxt;
	dap_pkg::fin_t      fin;
	logic               vld_s2;
	dap_pkg::fin_t      fin_s2;
	logic               out_vld_q;
	dap_pkg::out_item_t out_q;
	dap_pkg::out_item_t res;

	logic out_en;
	logic s2_en;
	logic consume;
	logic s1_en;

	assign out_en      = !out_vld_q || results.ready;
	assign s2_en       = !vld_s2 || out_en;
	assign consume     = vld_s1 && s2_en;
	assign s1_en       = !vld_s1 || consume;
	assign chars.ready = s1_en;

	assign results.valid = out_vld_q;
	assign results.data  = out_q;

	dap_parse #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parse (
		.cur       (state_q),
		.char_byte (char_s1),
		.last_char (last_s1),
		.nxt       (state_nxt),
		.fin       (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_en) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && chars.valid) begin
			char_s1 <= chars.data.char_byte;
			last_s1 <= chars.data.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dap_pkg::STATE_RESET;
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_en) begin
			vld_s2 <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1)
			fin_s2 <= fin;
	end

	// range check and sign application on the summary
	always_comb begin
		res.amount       = '0;
		res.noncanonical = 1'b0;
		res.status       = fin_s2.err;
		if (fin_s2.err == dap_pkg::ST_OK) begin
			if (fin_s2.scaled_big ||
				(fin_s2.neg && fin_s2.scaled > dap_pkg::NEG_LIMIT) ||
				(!fin_s2.neg && fin_s2.scaled[63])) begin
				res.status = dap_pkg::ST_OVERFLOW;
			end else begin
				res.amount       = fin_s2.neg ? -fin_s2.scaled : fin_s2.scaled;
				res.noncanonical = fin_s2.noncanon || (fin_s2.neg && fin_s2.scaled == 64'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_en) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && vld_s2)
			out_q <= res;
	end

endmodule

`default_nettype wire

// ===== rtl/core/dap_parse.sv =====
// ---------------------------------------------------------------------------
// Parser byte step
// Next-state logic for one string byte, plus the end-of-string summary.
// ---------------------------------------------------------------------------
`default_nettype none

module dap_parse #(
	parameter int FRACTION_DIGITS = 8
) (
	input  dap_pkg::state_t cur,
	input  logic [7:0]      char_byte,
	input  logic            last_char,
	output dap_pkg::state_t nxt,
	output dap_pkg::fin_t   fin
);

	dap_pkg::state_t st;
	logic            is_dig;
	logic [3:0]      dig;
	logic [63:0]     v10;
	logic [64:0]     mac_sum;
	logic            mac_ovf;
	logic [4:0]      jf;
	logic [63:0]     dp_int;
	logic [63:0]     dp_frac;
	logic [68:0]     sc_wide;
	logic [68:0]     sc_int;
	logic [64:0]     sc_frac;
	logic            frac_room;

	assign is_dig = (char_byte >= dap_pkg::CH_ZERO) && (char_byte <= dap_pkg::CH_NINE);
	assign dig    = 4'(char_byte - dap_pkg::CH_ZERO);

	// value * 10 + digit with unsigned wrap checks
	assign v10     = (cur.value << 3) + (cur.value << 1);
	assign mac_sum = {1'b0, v10} + {61'd0, dig};
	assign mac_ovf = (cur.value > dap_pkg::MAX_DIV10) || mac_sum[64];

	// scaled tracks the final amount so no multiply is needed at the end
	assign frac_room = cur.frac_cnt < dap_pkg::CNT_W'(FRACTION_DIGITS);
	assign jf        = frac_room ? 5'(FRACTION_DIGITS - 1) - 5'(cur.frac_cnt) : 5'd0;
	assign dp_int    = 64'(dig) * dap_pkg::POW10[5'(FRACTION_DIGITS)];
	assign dp_frac   = 64'(dig) * dap_pkg::POW10[jf];
	assign sc_wide   = {5'd0, cur.scaled};
	assign sc_int    = (sc_wide << 3) + (sc_wide << 1) + {5'd0, dp_int};
	assign sc_frac   = {1'b0, cur.scaled} + {1'b0, dp_frac};

	always_comb begin
		st = cur;
		if (cur.err == dap_pkg::ST_OK) begin
			unique case (cur.phase) inside
				dap_pkg::PH_START, dap_pkg::PH_SIGN: begin
					if (cur.phase == dap_pkg::PH_START && char_byte == dap_pkg::CH_MINUS) begin
						st.neg   = 1'b1;
						st.phase = dap_pkg::PH_SIGN;
					end else if (!is_dig) begin
						st.err = dap_pkg::ST_SYNTAX;
					end else begin
						st.first_zero = (char_byte == dap_pkg::CH_ZERO);
						st.phase      = dap_pkg::PH_INT;
						st.value      = mac_sum[63:0];
						st.scaled     = sc_int[63:0];
						st.scaled_big = cur.scaled_big || (sc_int[68:64] != 5'd0);
						if (mac_ovf)
							st.err = dap_pkg::ST_OVERFLOW;
					end
				end
				dap_pkg::PH_INT: begin
					if (cur.first_zero && char_byte != dap_pkg::CH_POINT)
						st.noncanon = 1'b1;
					st.first_zero = 1'b0;
					if (is_dig) begin
						st.value      = mac_sum[63:0];
						st.scaled     = sc_int[63:0];
						st.scaled_big = cur.scaled_big || (sc_int[68:64] != 5'd0);
						if (mac_ovf)
							st.err = dap_pkg::ST_OVERFLOW;
					end else if (char_byte == dap_pkg::CH_POINT) begin
						st.phase = dap_pkg::PH_FRAC;
					end else begin
						st.err = dap_pkg::ST_SYNTAX;
					end
				end
				dap_pkg::PH_FRAC: begin
					if (frac_room) begin
						if (!is_dig) begin
							st.err = dap_pkg::ST_SYNTAX;
						end else begin
							if (char_byte != dap_pkg::CH_ZERO)
								st.nz_frac = 1'b1;
							st.frac_cnt   = cur.frac_cnt + dap_pkg::CNT_W'(1);
							st.value      = mac_sum[63:0];
							st.scaled     = sc_frac[63:0];
							st.scaled_big = cur.scaled_big || sc_frac[64];
							if (mac_ovf)
								st.err = dap_pkg::ST_OVERFLOW;
						end
					end else if (char_byte != dap_pkg::CH_ZERO) begin
						st.err = dap_pkg::ST_SYNTAX;
					end else begin
						st.noncanon = 1'b1;
					end
				end
				default: st = cur;
			endcase
		end
	end

	always_comb begin
		fin.scaled     = st.scaled;
		fin.scaled_big = st.scaled_big;
		fin.neg        = st.neg;
		fin.noncanon   = st.noncanon;
		fin.err        = st.err;
		// lone minus sign
		if (st.err == dap_pkg::ST_OK && st.phase == dap_pkg::PH_SIGN)
			fin.err = dap_pkg::ST_SYNTAX;
		// empty, trailing-zero or all-zero fraction
		if (st.phase == dap_pkg::PH_FRAC &&
			(char_byte == dap_pkg::CH_ZERO || char_byte == dap_pkg::CH_POINT || !st.nz_frac))
			fin.noncanon = 1'b1;
		nxt = last_char ? dap_pkg::STATE_RESET : st;
	end

endmodule

`default_nettype wire
